// File: src/iase_pkg.sv
// Shared types, constants and priority tables for the infix add/subtract evaluator.
`default_nettype none

package iase_pkg;

  localparam int unsigned OPERATOR_DEPTH = 32;
  localparam int unsigned VALUE_DEPTH    = 32;

  localparam int unsigned OP_AW  = $clog2(OPERATOR_DEPTH);
  localparam int unsigned OP_CW  = $clog2(OPERATOR_DEPTH + 1);
  localparam int unsigned VAL_AW = $clog2(VALUE_DEPTH);
  localparam int unsigned VAL_CW = $clog2(VALUE_DEPTH + 1);

  localparam int unsigned DATA_W = 32;

  // ASCII characters the evaluator reacts to
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  typedef enum logic [2:0] {
    OP_END   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_OPEN  = 3'd3,
    OP_CLOSE = 3'd4
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic acc;          // fold the input digit into the pending number
    logic flush;        // push the pending number if there is one
    logic op_push;      // push op onto the operator stack
    logic op_pop;       // pop the operator stack, keep the popped symbol
    logic op_top_load;  // reload the cached operator top from memory
    logic apply;        // combine the two top values with the popped symbol
    logic set_err1;     // flag a malformed expression
    logic out_load;     // capture the result word
    logic clear;        // return the expression state to reset
    op_e  op;           // operator being handled
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_digit;
    logic in_op_known;
    op_e  in_op;
    logic op_empty;
    logic lvl_lt;       // incoming priority below the stacked one
    logic lvl_eq;
    logic sym_arith;    // popped symbol is add or subtract
    logic val_ge2;      // at least two values stacked
  } sts_t;

  function automatic logic [2:0] prio_in(op_e op);
    logic [2:0] p;
    unique case (op)
      OP_END:   p = 3'd0;
      OP_ADD:   p = 3'd3;
      OP_SUB:   p = 3'd3;
      OP_OPEN:  p = 3'd1;
      OP_CLOSE: p = 3'd4;
      default:  p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] prio_out(op_e op);
    logic [2:0] p;
    unique case (op)
      OP_END:   p = 3'd0;
      OP_ADD:   p = 3'd2;
      OP_SUB:   p = 3'd2;
      OP_OPEN:  p = 3'd4;
      OP_CLOSE: p = 3'd1;
      default:  p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: src/iase_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module iase_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/iase_datapath.sv
// Datapath: pending number, operator and value stacks, arithmetic and result register.
`default_nettype none

module iase_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           character_i,
  input  wire iase_pkg::cmd_t       cmd_i,
  output iase_pkg::sts_t            sts_o,
  output logic signed [31:0]        value_o,
  output logic [1:0]                status_o
);

  import iase_pkg::*;

  logic [OP_CW-1:0]   op_cnt_q, op_cnt_d;
  logic [VAL_CW-1:0]  val_cnt_q, val_cnt_d;
  logic [DATA_W-1:0]  pend_q, pend_d;
  logic               active_q, active_d;
  logic [1:0]         err_q, err_d;
  op_e                op_top_q, op_top_d;
  op_e                pop_sym_q, pop_sym_d;
  logic [DATA_W-1:0]  val_top_q, val_top_d;
  logic signed [31:0] out_value_q, out_value_d;
  logic [1:0]         out_status_q, out_status_d;

  logic [OP_CW-1:0]   op_cnt_m2;
  logic [VAL_CW-1:0]  val_cnt_m2;
  logic               op_full, val_full;
  logic               op_we, val_we;
  logic [VAL_AW-1:0]  val_waddr;
  logic [DATA_W-1:0]  val_wdata;
  logic [2:0]         op_rdata;
  logic [DATA_W-1:0]  val_rdata;
  logic [DATA_W-1:0]  sum;
  logic [3:0]         digit;

  assign op_cnt_m2  = op_cnt_q - OP_CW'(2);
  assign val_cnt_m2 = val_cnt_q - VAL_CW'(2);
  assign op_full    = (op_cnt_q == OP_CW'(OPERATOR_DEPTH));
  assign val_full   = (val_cnt_q == VAL_CW'(VALUE_DEPTH));
  assign digit      = 4'(character_i - CH_ZERO);
  assign sum        = (pop_sym_q == OP_ADD) ? (val_rdata + val_top_q) : (val_rdata - val_top_q);

  assign op_we     = cmd_i.op_push && !op_full;
  assign val_we    = (cmd_i.flush && active_q && !val_full) || cmd_i.apply;
  assign val_waddr = cmd_i.apply ? val_cnt_m2[VAL_AW-1:0] : val_cnt_q[VAL_AW-1:0];
  assign val_wdata = cmd_i.apply ? sum : pend_q;

  iase_ram #(
    .WIDTH (3),
    .DEPTH (OPERATOR_DEPTH)
  ) u_op_ram (
    .clk_i   (clk_i),
    .we_i    (op_we),
    .waddr_i (op_cnt_q[OP_AW-1:0]),
    .wdata_i (cmd_i.op),
    .raddr_i (op_cnt_m2[OP_AW-1:0]),
    .rdata_o (op_rdata)
  );

  iase_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VALUE_DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_cnt_m2[VAL_AW-1:0]),
    .rdata_o (val_rdata)
  );

  // decode the incoming character and the priority compare
  always_comb begin
    sts_o             = '0;
    sts_o.in_op       = OP_END;
    sts_o.in_digit    = (character_i >= CH_ZERO) && (character_i <= CH_NINE);
    case (character_i)
      CH_PLUS:  begin sts_o.in_op_known = 1'b1; sts_o.in_op = OP_ADD;   end
      CH_MINUS: begin sts_o.in_op_known = 1'b1; sts_o.in_op = OP_SUB;   end
      CH_OPEN:  begin sts_o.in_op_known = 1'b1; sts_o.in_op = OP_OPEN;  end
      CH_CLOSE: begin sts_o.in_op_known = 1'b1; sts_o.in_op = OP_CLOSE; end
      default:  sts_o.in_op_known = 1'b0;
    endcase
    sts_o.op_empty  = (op_cnt_q == '0);
    sts_o.lvl_lt    = prio_out(cmd_i.op) < prio_in(op_top_q);
    sts_o.lvl_eq    = prio_out(cmd_i.op) == prio_in(op_top_q);
    sts_o.sym_arith = (pop_sym_q == OP_ADD) || (pop_sym_q == OP_SUB);
    sts_o.val_ge2   = (val_cnt_q >= VAL_CW'(2));
  end

  always_comb begin
    op_cnt_d     = op_cnt_q;
    val_cnt_d    = val_cnt_q;
    pend_d       = pend_q;
    active_d     = active_q;
    err_d        = err_q;
    op_top_d     = op_top_q;
    pop_sym_d    = pop_sym_q;
    val_top_d    = val_top_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    if (cmd_i.acc) begin
      pend_d   = (pend_q << 3) + (pend_q << 1) + {{(DATA_W-4){1'b0}}, digit};
      active_d = 1'b1;
    end

    if (cmd_i.flush && active_q) begin
      if (val_full) begin
        if (err_q == STATUS_OK) err_d = STATUS_OVERFLOW;
      end else begin
        val_top_d = pend_q;
        val_cnt_d = val_cnt_q + VAL_CW'(1);
      end
      pend_d   = '0;
      active_d = 1'b0;
    end

    if (cmd_i.op_push) begin
      if (op_full) begin
        if (err_q == STATUS_OK) err_d = STATUS_OVERFLOW;
      end else begin
        op_top_d = cmd_i.op;
        op_cnt_d = op_cnt_q + OP_CW'(1);
      end
    end

    if (cmd_i.op_pop) begin
      pop_sym_d = op_top_q;
      op_cnt_d  = op_cnt_q - OP_CW'(1);
    end

    if (cmd_i.op_top_load) begin
      op_top_d = op_e'(op_rdata);
    end

    if (cmd_i.apply) begin
      val_top_d = sum;
      val_cnt_d = val_cnt_q - VAL_CW'(1);
    end

    if (cmd_i.set_err1 && (err_q == STATUS_OK)) begin
      err_d = STATUS_MALFORMED;
    end

    if (cmd_i.out_load) begin
      out_value_d = (val_cnt_q == '0) ? '0 : $signed(val_top_q);
      if (err_q != STATUS_OK) begin
        out_status_d = err_q;
      end else begin
        out_status_d = (val_cnt_q == '0) ? STATUS_MALFORMED : STATUS_OK;
      end
    end

    if (cmd_i.clear) begin
      op_cnt_d  = '0;
      val_cnt_d = '0;
      pend_d    = '0;
      active_d  = 1'b0;
      err_d     = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_cnt_q  <= '0;
      val_cnt_q <= '0;
      pend_q    <= '0;
      active_q  <= 1'b0;
      err_q     <= STATUS_OK;
    end else begin
      op_cnt_q  <= op_cnt_d;
      val_cnt_q <= val_cnt_d;
      pend_q    <= pend_d;
      active_q  <= active_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_top_q     <= op_top_d;
    pop_sym_q    <= pop_sym_d;
    val_top_q    <= val_top_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign value_o  = out_value_q;
  assign status_o = out_status_q;

endmodule

`default_nettype wire

// File: src/iase_ctrl.sv
// Controller: sequences character handling, stack pops, arithmetic and result hand-off.
`default_nettype none

module iase_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           end_of_text_i,
  input  wire logic           out_ready_i,
  input  wire iase_pkg::sts_t sts_i,
  output iase_pkg::cmd_t      cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);

  import iase_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH,
    S_OP,
    S_OPTOP,
    S_APPLY,
    S_NEXT,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  op_e    cur_op_q, cur_op_d;
  logic   op_known_q, op_known_d;
  logic   last_q, last_d;
  logic   fin_q, fin_d;
  logic   apply_q, apply_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cur_op_d    = cur_op_q;
    op_known_d  = op_known_q;
    last_d      = last_q;
    fin_d       = fin_q;
    apply_d     = apply_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.op    = cur_op_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = end_of_text_i;
          if (sts_i.in_digit) begin
            cmd_o.acc  = 1'b1;
            op_known_d = 1'b0;
            state_d    = end_of_text_i ? S_FLUSH : S_IDLE;
          end else begin
            op_known_d = sts_i.in_op_known;
            cur_op_d   = sts_i.in_op;
            state_d    = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = op_known_q ? S_OP : S_NEXT;
      end
      S_OP: begin
        if (!sts_i.op_empty && sts_i.lvl_lt) begin
          cmd_o.op_pop = 1'b1;
          apply_d      = 1'b1;
          state_d      = S_OPTOP;
        end else if (!sts_i.op_empty && sts_i.lvl_eq) begin
          cmd_o.op_pop = 1'b1;
          apply_d      = 1'b0;
          state_d      = S_OPTOP;
        end else begin
          cmd_o.op_push = 1'b1;
          state_d       = S_NEXT;
        end
      end
      S_OPTOP: begin
        cmd_o.op_top_load = 1'b1;
        if (!apply_q) begin
          state_d = S_NEXT;
        end else if (sts_i.sym_arith && sts_i.val_ge2) begin
          state_d = S_APPLY;
        end else begin
          cmd_o.set_err1 = sts_i.sym_arith;
          state_d        = S_OP;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_OP;
      end
      S_NEXT: begin
        if (last_q) begin
          cur_op_d = OP_END;
          last_d   = 1'b0;
          fin_d    = 1'b1;
          state_d  = S_OP;
        end else if (fin_q) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          out_valid_d    = 1'b1;
          fin_d          = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_op_q    <= OP_END;
      op_known_q  <= 1'b0;
      last_q      <= 1'b0;
      fin_q       <= 1'b0;
      apply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_op_q    <= cur_op_d;
      op_known_q  <= op_known_d;
      last_q      <= last_d;
      fin_q       <= fin_d;
      apply_q     <= apply_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/infix_add_sub_evaluator_core.sv
// Top level of the infix add/subtract expression evaluator.
//
// Usage: feed the expression text one ASCII character per input word on the
// valid/ready input channel (character_i, end_of_text_i). Digits build a decimal
// number, '+', '-', '(' and ')' go through an operator-precedence two-stack
// scheme, spaces and any other byte just end the number being typed. The word
// with end_of_text_i set closes the expression: the operator stack is emptied and
// one result word (value_o, status_o) appears on the output channel. Status 0 is
// ok, 1 a malformed expression, 2 a stack overflow; the first error sticks.
//
// Sequencing: a digit that does not end the text is taken in the idle state.
// Any other character passes the flush state and, for an operator, the compare
// state, which pops the operator stack or stacks the operator. Each pop waits on
// the registered read of the operator stack memory and each add or subtract on
// that of the value stack memory. Closing the text adds the end-mark pass, with
// the same pops and add/subtract steps, and the result register load, held back
// while that register still holds an unaccepted word.
// One character is in work at a time; in_ready_o is high only when idle.
//
// Reset clears all counters and flags; stack memories need no clearing since only
// entries below the counts are read. A stalled receiver holds the result word in
// the output register; the next expression is accepted meanwhile and only its
// own result waits until that register is free.
`default_nettype none

module infix_add_sub_evaluator_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         character_i,
  input  wire logic               end_of_text_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      value_o,
  output logic [1:0]              status_o
);

  import iase_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decides what the datapath does each cycle
  iase_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .end_of_text_i (end_of_text_i),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o)
  );

  // stacks, number accumulator, adder and the result register
  iase_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .character_i (character_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

// File: src/iase_checker.sv
// Port-level checker for the evaluator, bound to the top level.
`default_nettype none

module iase_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [7:0]        character_i,
  input wire logic              end_of_text_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic signed [31:0] value_o,
  input wire logic [1:0]        status_o
);

  import iase_pkg::*;

  logic [1:0] open_q, open_d;
  logic       end_acc, out_acc;

  assign end_acc = in_valid_i && in_ready_o && end_of_text_i;
  assign out_acc = out_valid_o && out_ready_i;

  // expressions closed but not yet delivered
  always_comb begin
    open_d = open_q;
    if (end_acc && !out_acc) open_d = open_q + 2'd1;
    if (!end_acc && out_acc) open_d = open_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(status_o))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK) || (status_o == STATUS_MALFORMED) ||
                    (status_o == STATUS_OVERFLOW))
    else $error("undefined status code");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != 2'd0)
    else $error("result without a closed expression");

  a_busy_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_acc |=> !in_ready_o)
    else $error("input taken while closing an expression");

endmodule

bind infix_add_sub_evaluator_core iase_checker u_iase_checker (.*);

`default_nettype wire
